// ----- src/gdc_pkg.sv -----
// Shared constants, types and the saturation helper for the gyro drift compensator.
// Depends on nothing; every other file in src uses it by scoped names.

package gdc_pkg;

   localparam int DataW   = 32;  // sample, time and angle words
   localparam int CfgW    = 16;  // configuration register width
   localparam int CsrIdxW = 8;   // configuration register index width
   localparam int SatW    = 36;  // headroom for sums before saturation

   localparam logic [CfgW-1:0] IntervalReset  = 16'd250;
   localparam logic [CfgW-1:0] ThresholdReset = 16'd300;

   // Half and full turn in centidegrees
   localparam int HalfTurn = 18000;
   localparam int FullTurn = 36000;

   typedef enum logic [CsrIdxW-1:0] {
      RegDriftInterval  = 8'd0,
      RegDriftThreshold = 8'd1
   } csr_reg_type;

   typedef struct packed {
      logic [CfgW-1:0] interval_ms;
      logic [CfgW-1:0] threshold;
   } drift_cfg_type;

   // Clamp a wide signed sum to the signed 32-bit range
   function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
      logic signed [SatW-1:0] max_v;
      logic signed [SatW-1:0] min_v;
      max_v = {{(SatW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
      min_v = {{(SatW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
      if (v > max_v) begin
         return max_v[DataW-1:0];
      end else if (v < min_v) begin
         return min_v[DataW-1:0];
      end
      return v[DataW-1:0];
   endfunction

endpackage

// ----- src/gdc_if.sv -----
// Valid/ready channel interfaces for the gyro drift compensator: sample in, angle out, csr.
// Depends on gdc_pkg for the field widths.

interface gdc_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [gdc_pkg::DataW-1:0]  gyro_sample;
   logic        [gdc_pkg::DataW-1:0]  time_ms;

   modport source (output valid, gyro_sample, time_ms, input ready);
   modport sink   (input valid, gyro_sample, time_ms, output ready);
endinterface

interface gdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [gdc_pkg::DataW-1:0]  angle;
   logic signed [gdc_pkg::DataW-1:0]  unwrapped_angle;
   logic                              angle_valid;

   modport source (output valid, angle, unwrapped_angle, angle_valid, input ready);
   modport sink   (input valid, angle, unwrapped_angle, angle_valid, output ready);
endinterface

interface gdc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gdc_pkg::CsrIdxW-1:0]       index;
   logic [gdc_pkg::CfgW-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/gyro_drift_compensator_core.sv -----
// Top level of the gyro drift compensator: input register, drift check, angle and delta fold stages, output register.
// Depends on gdc_pkg, the interfaces in gdc_if and gdc_drift_track.

// Usage
//   req_chan : one word per gyro sample (signed centidegrees) with its millisecond
//              timestamp; accepted on a clock edge with valid and ready high.
//   rsp_chan : one word per accepted sample: drift-corrected angle, accumulated
//              absolute angle (deltas folded into +-180 degrees) and angle_valid.
//   csr_chan : register writes; index 0 drift interval in ms, index 1 drift
//              threshold in centidegrees. Unknown indexes are dropped. Write only
//              while no sample is in flight. csr_chan.ready is always high.
// Timing
//   One sample is taken every cycle while rsp_chan does not stall; the rate is
//   set by the five-register pipeline (input, drift check, angle, delta fold,
//   output/accumulator), each stage holding its own slice of the state so that
//   back-to-back samples chain.
// Reset
//   Synchronous, active high: registers return to 250 ms and 300 centidegrees,
//   all accumulators and the check point clear, the pipeline empties.
// Stall
//   A result held on rsp_chan freezes only the output stage; earlier stages keep
//   filling bubbles, and req_chan.ready drops once every stage is occupied.

module gyro_drift_compensator_core (
   input logic       clock,
   input logic       reset,
   gdc_req_if.sink   req_chan,
   gdc_rsp_if.source rsp_chan,
   gdc_csr_if.sink   csr_chan
);

   localparam int DW     = gdc_pkg::DataW;
   localparam int DeltaW = DW + 2;

   // Configuration registers
   gdc_pkg::drift_cfg_type cfg_ff;

   // Stage valids and ready chain
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;
   logic fire0, fire1, fire2, fire3, fire4;

   // Stage payloads
   logic signed [DW-1:0]     s0_sample_ff;
   logic        [DW-1:0]     s0_time_ff;
   logic signed [DW-1:0]     s1_sample_ff;
   logic signed [DW-1:0]     s2_angle_ff;
   logic signed [DW-1:0]     s3_angle_ff;
   logic signed [DeltaW-1:0] s3_delta_ff;
   logic signed [DW-1:0]     rsp_angle_ff;

   // Per-stage state
   logic signed [DW-1:0] prev_angle_ff;
   logic signed [DW-1:0] unwrapped_ff;
   logic                 seen_ff;

   logic signed [DW-1:0]     correction;
   logic signed [DW-1:0]     angle_in;
   logic signed [DeltaW-1:0] delta_raw;
   logic signed [DeltaW-1:0] delta_in;
   logic signed [DW-1:0]     unwrapped_in;

   // A stage may load when it is empty or its word moves on this edge
   always_comb begin
      rdy4  = !rsp_valid_ff || rsp_chan.ready;
      rdy3  = !s3_valid_ff || rdy4;
      rdy2  = !s2_valid_ff || rdy3;
      rdy1  = !s1_valid_ff || rdy2;
      rdy0  = !s0_valid_ff || rdy1;
      fire0 = req_chan.valid && rdy0;
      fire1 = s0_valid_ff && rdy1;
      fire2 = s1_valid_ff && rdy2;
      fire3 = s2_valid_ff && rdy3;
      fire4 = s3_valid_ff && rdy4;
   end

   assign req_chan.ready = rdy0;
   assign csr_chan.ready = 1'b1;

   // Drift check on the word in the input register
   gdc_drift_track u_drift (
      .clock      (clock),
      .reset      (reset),
      .advance    (fire1),
      .sample     (s0_sample_ff),
      .time_ms    (s0_time_ff),
      .cfg        (cfg_ff),
      .correction (correction)
   );

   always_comb begin
      // Corrected angle
      angle_in  = gdc_pkg::sat32(gdc_pkg::SatW'(s1_sample_ff) + gdc_pkg::SatW'(correction));
      // Step-to-step change, folded once into +-half a turn
      delta_raw = DeltaW'(s2_angle_ff) - DeltaW'(prev_angle_ff);
      if (delta_raw > DeltaW'(gdc_pkg::HalfTurn)) begin
         delta_in = delta_raw - DeltaW'(gdc_pkg::FullTurn);
      end else if (delta_raw < -DeltaW'(gdc_pkg::HalfTurn)) begin
         delta_in = delta_raw + DeltaW'(gdc_pkg::FullTurn);
      end else begin
         delta_in = delta_raw;
      end
      // Absolute angle accumulator
      unwrapped_in = gdc_pkg::sat32(gdc_pkg::SatW'(unwrapped_ff) + gdc_pkg::SatW'(s3_delta_ff));
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ms <= gdc_pkg::IntervalReset;
         cfg_ff.threshold   <= gdc_pkg::ThresholdReset;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_angle_ff <= '0;
         unwrapped_ff  <= '0;
         seen_ff       <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            unique case (gdc_pkg::csr_reg_type'(csr_chan.index))
               gdc_pkg::RegDriftInterval:  cfg_ff.interval_ms <= csr_chan.data;
               gdc_pkg::RegDriftThreshold: cfg_ff.threshold   <= csr_chan.data;
               default: ;  // drop writes to unknown registers
            endcase
         end
         if (rdy0) s0_valid_ff  <= req_chan.valid;
         if (rdy1) s1_valid_ff  <= s0_valid_ff;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) rsp_valid_ff <= s3_valid_ff;
         if (fire3) begin
            prev_angle_ff <= s2_angle_ff;
         end
         if (fire4) begin
            unwrapped_ff <= unwrapped_in;
            seen_ff      <= 1'b1;
         end
      end
   end

   // Payload: advance with the valids, hold otherwise
   always_ff @(posedge clock) begin
      if (fire0) begin
         s0_sample_ff <= req_chan.gyro_sample;
         s0_time_ff   <= req_chan.time_ms;
      end
      if (fire1) s1_sample_ff <= s0_sample_ff;
      if (fire2) s2_angle_ff  <= angle_in;
      if (fire3) begin
         s3_angle_ff <= s2_angle_ff;
         s3_delta_ff <= delta_in;
      end
      if (fire4) rsp_angle_ff <= s3_angle_ff;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.angle           = rsp_angle_ff;
   assign rsp_chan.unwrapped_angle = unwrapped_ff;
   assign rsp_chan.angle_valid     = seen_ff;

`ifndef SYNTHESIS
   // Any result shown must come after at least one processed sample
   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.angle_valid)
      else $error("result shown without angle_valid");

   // A full pipeline behind a stalled output must refuse new samples
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready && s0_valid_ff && s1_valid_ff
       && s2_valid_ff && s3_valid_ff) |-> !req_chan.ready)
      else $error("sample accepted into a full pipeline");

   // An accepted sample lands in the input register
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s0_valid_ff)
      else $error("accepted sample lost at input register");

   // Drift correction moves only when the drift stage takes a word
   a_corr_hold: assert property (@(posedge clock) disable iff (reset)
      !fire1 |=> $stable(correction))
      else $error("drift correction changed without a sample");
`endif

endmodule

// ----- src/gdc_drift_track.sv -----
// Drift check point and drift correction accumulator for the gyro drift compensator.
// Depends on gdc_pkg for widths, the config struct and sat32.

module gdc_drift_track (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic signed [gdc_pkg::DataW-1:0]  sample,
   input  logic        [gdc_pkg::DataW-1:0]  time_ms,
   input  gdc_pkg::drift_cfg_type            cfg,
   output logic signed [gdc_pkg::DataW-1:0]  correction
);

   localparam int ChangeW = gdc_pkg::DataW + 1;

   logic signed [gdc_pkg::DataW-1:0] last_sample_ff;
   logic        [gdc_pkg::DataW-1:0] last_time_ff;
   logic signed [gdc_pkg::DataW-1:0] correction_ff;
   logic signed [gdc_pkg::DataW-1:0] correction_in;

   logic [gdc_pkg::DataW-1:0] elapsed;
   logic                      check;
   logic signed [ChangeW-1:0] change;
   logic        [ChangeW-1:0] mag;
   logic                      is_drift;

   always_comb begin
      elapsed  = time_ms - last_time_ff;
      check    = elapsed > {{(gdc_pkg::DataW-gdc_pkg::CfgW){1'b0}}, cfg.interval_ms};
      change   = ChangeW'(last_sample_ff) - ChangeW'(sample);
      mag      = change[ChangeW-1] ? ChangeW'(-change) : ChangeW'(change);
      is_drift = mag < {{(ChangeW-gdc_pkg::CfgW){1'b0}}, cfg.threshold};
      correction_in = gdc_pkg::sat32(gdc_pkg::SatW'(correction_ff)
                                     + gdc_pkg::SatW'(change));
   end

   // Move the check point only when enough time has passed
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         last_time_ff   <= '0;
         correction_ff  <= '0;
      end else if (advance && check) begin
         last_sample_ff <= sample;
         last_time_ff   <= time_ms;
         if (is_drift) begin
            correction_ff <= correction_in;
         end
      end
   end

   assign correction = correction_ff;

endmodule
